@@ sv/gpu_command_word_framer_macros.svh @@
// Assertion macros for the command word framer.
// Included by the top level; no other dependencies.
`ifndef GPU_COMMAND_WORD_FRAMER_MACROS_SVH
`define GPU_COMMAND_WORD_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gcwf_pkg.sv @@
// Shared types, codes and opcode tables for the command word framer.
// No dependencies.
package gcwf_pkg;

    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 8;
    localparam int INDEX_W  = 4;
    localparam int ERR_W    = 2;
    localparam int DMODE_W  = 14;
    localparam int TWIN_W   = 20;
    localparam int AREA_W   = 20;
    localparam int OFFS_W   = 22;
    localparam int MASK_W   = 2;

    localparam int MAX_PACKET_WORDS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_OP = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TEX_DEPTH  = 2'd2;

    // reserved texture depth code in the draw mode word
    localparam logic [1:0] TEX_DEPTH_RSVD = 2'b11;

    // opcodes that matter outside the length table
    localparam logic [OPCODE_W-1:0] OP_NOP        = 8'h00;
    localparam logic [OPCODE_W-1:0] OP_TEX_RECT16 = 8'h7C;
    localparam logic [OPCODE_W-1:0] OP_VRAM_COPY  = 8'h80;
    localparam logic [OPCODE_W-1:0] OP_DRAW_MODE  = 8'hE1;
    localparam logic [OPCODE_W-1:0] OP_TEX_WINDOW = 8'hE2;
    localparam logic [OPCODE_W-1:0] OP_AREA_TL    = 8'hE3;
    localparam logic [OPCODE_W-1:0] OP_AREA_BR    = 8'hE4;
    localparam logic [OPCODE_W-1:0] OP_DRAW_OFFS  = 8'hE5;
    localparam logic [OPCODE_W-1:0] OP_MASK_BIT   = 8'hE6;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_DRAW_MODE,
        SEL_TEX_WINDOW,
        SEL_AREA_TL,
        SEL_AREA_BR,
        SEL_DRAW_OFFS,
        SEL_MASK
    } t_reg_sel;

    // one classified word on its way from front to back
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic                last;
        logic                fwd;
        logic [ERR_W-1:0]    err;
        t_reg_sel            sel;
    } t_q_item;

    // packet length in words, 0 for an unknown opcode
    function automatic logic [INDEX_W-1:0] packet_length(input logic [OPCODE_W-1:0] op);
        logic [INDEX_W-1:0] len;
        case (op)
            8'h00, 8'h01:                      len = 4'd1;
            8'h02:                             len = 4'd3;
            8'h20:                             len = 4'd4;
            8'h28, 8'h29, 8'h2A, 8'h2B:        len = 4'd5;
            8'h2C, 8'h2D, 8'h2F:               len = 4'd9;
            8'h30:                             len = 4'd6;
            8'h38:                             len = 4'd8;
            8'h3C, 8'h3E:                      len = 4'd12;
            8'h40, 8'h60:                      len = 4'd3;
            8'h63, 8'h64, 8'h65, 8'h66:        len = 4'd4;
            8'h68:                             len = 4'd2;
            8'h75, 8'h7C:                      len = 4'd3;
            8'h80:                             len = 4'd5;
            8'hA0, 8'hC0:                      len = 4'd3;
            8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6: len = 4'd1;
            default:                           len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic goes_to_renderer(input logic [OPCODE_W-1:0] op);
        logic fwd;
        fwd = (packet_length(op) != 4'd0);
        if (op == OP_NOP || op == OP_TEX_RECT16 || op == OP_VRAM_COPY) begin
            fwd = 1'b0;
        end
        if (op >= OP_DRAW_MODE && op <= OP_MASK_BIT) begin
            fwd = 1'b0;
        end
        return fwd;
    endfunction

endpackage

@@ sv/gcwf_if.sv @@
// Valid/ready channel interfaces for command words and framed results.
// Depends on gcwf_pkg.
interface gcwf_cmd_if import gcwf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] cmd_word;

    modport source (output valid, output cmd_word, input ready);
    modport sink   (input valid, input cmd_word, output ready);
endinterface

interface gcwf_res_if import gcwf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   word_out;
    logic [OPCODE_W-1:0] packet_opcode;
    logic [INDEX_W-1:0]  word_index;
    logic                packet_end;
    logic                forward_to_renderer;
    logic [ERR_W-1:0]    error_code;
    logic [DMODE_W-1:0]  draw_mode_bits;
    logic [TWIN_W-1:0]   texture_window_bits;
    logic [AREA_W-1:0]   area_top_left_bits;
    logic [AREA_W-1:0]   area_bottom_right_bits;
    logic [OFFS_W-1:0]   draw_offset_bits;
    logic [MASK_W-1:0]   mask_setting_bits;

    modport source (
        output valid, output word_out, output packet_opcode, output word_index,
        output packet_end, output forward_to_renderer, output error_code,
        output draw_mode_bits, output texture_window_bits, output area_top_left_bits,
        output area_bottom_right_bits, output draw_offset_bits, output mask_setting_bits,
        input ready
    );
    modport sink (
        input valid, input word_out, input packet_opcode, input word_index,
        input packet_end, input forward_to_renderer, input error_code,
        input draw_mode_bits, input texture_window_bits, input area_top_left_bits,
        input area_bottom_right_bits, input draw_offset_bits, input mask_setting_bits,
        output ready
    );
endinterface

@@ sv/gcwf_front.sv @@
// Front end: frames command words into packets and classifies each word.
// Depends on gcwf_pkg and gcwf_if.
module gcwf_front import gcwf_pkg::*; #(
    parameter int MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcwf_cmd_if.sink   i_cmd,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_q_item    o_push_item
);

    localparam logic [INDEX_W:0]   CAP_CMP = (INDEX_W+1)'(MAX_PACKET_WORDS);
    localparam logic [INDEX_W-1:0] CAP_LEN = INDEX_W'(MAX_PACKET_WORDS);

    logic [INDEX_W-1:0]  r_words_left, n_words_left;
    logic [OPCODE_W-1:0] r_cur_op, n_cur_op;
    logic [INDEX_W-1:0]  r_pos, n_pos;

    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  tbl_len;
    logic [INDEX_W-1:0]  len;
    logic [INDEX_W-1:0]  wl;
    logic [INDEX_W-1:0]  wl_dec;
    logic                idle;
    logic                unknown;
    logic                last;
    logic                accept;
    logic [ERR_W-1:0]    err;
    t_reg_sel            sel;

    assign i_cmd.ready  = i_push_ready;
    assign o_push_valid = i_cmd.valid;
    assign accept       = i_cmd.valid && i_push_ready;

    always_comb begin
        op      = i_cmd.cmd_word[WORD_W-1 -: OPCODE_W];
        tbl_len = packet_length(op);
        idle    = (r_words_left == '0);
        unknown = (tbl_len == '0);

        len = unknown ? INDEX_W'(1) : tbl_len;
        if ({1'b0, len} > CAP_CMP) begin
            len = CAP_LEN;
        end
        if (len == '0) begin
            len = INDEX_W'(1);
        end

        n_cur_op = idle ? op : r_cur_op;
        wl       = idle ? len : r_words_left;
        wl_dec   = wl - INDEX_W'(1);
        last     = (wl_dec == '0);
        n_pos    = last ? '0 : ((idle ? '0 : r_pos) + INDEX_W'(1));
        n_words_left = wl_dec;

        err = (idle && unknown) ? ERR_UNKNOWN_OP : ERR_NONE;

        sel = SEL_NONE;
        if (last && err == ERR_NONE) begin
            case (n_cur_op)
                OP_DRAW_MODE:  sel = SEL_DRAW_MODE;
                OP_TEX_WINDOW: sel = SEL_TEX_WINDOW;
                OP_AREA_TL:    sel = SEL_AREA_TL;
                OP_AREA_BR:    sel = SEL_AREA_BR;
                OP_DRAW_OFFS:  sel = SEL_DRAW_OFFS;
                OP_MASK_BIT:   sel = SEL_MASK;
                default:       sel = SEL_NONE;
            endcase
        end
        // reserved texture depth still loads the register
        if (sel == SEL_DRAW_MODE && i_cmd.cmd_word[8:7] == TEX_DEPTH_RSVD) begin
            err = ERR_TEX_DEPTH;
        end

        o_push_item.word   = i_cmd.cmd_word;
        o_push_item.opcode = n_cur_op;
        o_push_item.index  = idle ? '0 : r_pos;
        o_push_item.last   = last;
        o_push_item.fwd    = goes_to_renderer(n_cur_op);
        o_push_item.err    = err;
        o_push_item.sel    = sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_left <= '0;
            r_cur_op     <= '0;
            r_pos        <= '0;
        end else if (accept) begin
            r_words_left <= n_words_left;
            r_cur_op     <= n_cur_op;
            r_pos        <= n_pos;
        end
    end

endmodule

@@ sv/gcwf_queue.sv @@
// Short FIFO of classified words between front and back ends.
// Depends on gcwf_pkg.
module gcwf_queue import gcwf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_q_item i_push_item,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_q_item o_pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_q_item            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ sv/gcwf_back.sv @@
// Back end: applies state commands and holds the output register.
// Depends on gcwf_pkg and gcwf_if.
module gcwf_back import gcwf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_q_item    i_pop_item,
    gcwf_res_if.source o_res
);

    logic                r_valid;
    t_q_item             r_item;
    logic [DMODE_W-1:0]  r_draw_mode, n_draw_mode;
    logic [TWIN_W-1:0]   r_tex_window, n_tex_window;
    logic [AREA_W-1:0]   r_area_tl, n_area_tl;
    logic [AREA_W-1:0]   r_area_br, n_area_br;
    logic [OFFS_W-1:0]   r_draw_offs, n_draw_offs;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic                pop;

    assign o_pop_ready = !r_valid || o_res.ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_draw_mode  = r_draw_mode;
        n_tex_window = r_tex_window;
        n_area_tl    = r_area_tl;
        n_area_br    = r_area_br;
        n_draw_offs  = r_draw_offs;
        n_mask       = r_mask;
        case (i_pop_item.sel)
            SEL_DRAW_MODE:  n_draw_mode  = i_pop_item.word[DMODE_W-1:0];
            SEL_TEX_WINDOW: n_tex_window = i_pop_item.word[TWIN_W-1:0];
            SEL_AREA_TL:    n_area_tl    = i_pop_item.word[AREA_W-1:0];
            SEL_AREA_BR:    n_area_br    = i_pop_item.word[AREA_W-1:0];
            SEL_DRAW_OFFS:  n_draw_offs  = i_pop_item.word[OFFS_W-1:0];
            SEL_MASK:       n_mask       = i_pop_item.word[MASK_W-1:0];
            default:        ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_draw_mode  <= '0;
            r_tex_window <= '0;
            r_area_tl    <= '0;
            r_area_br    <= '0;
            r_draw_offs  <= '0;
            r_mask       <= '0;
        end else begin
            if (pop) begin
                r_valid      <= 1'b1;
                r_draw_mode  <= n_draw_mode;
                r_tex_window <= n_tex_window;
                r_area_tl    <= n_area_tl;
                r_area_br    <= n_area_br;
                r_draw_offs  <= n_draw_offs;
                r_mask       <= n_mask;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_pop_item;
        end
    end

    // state registers and r_item update on the same edge, so they always agree
    assign o_res.valid                  = r_valid;
    assign o_res.word_out               = r_item.word;
    assign o_res.packet_opcode          = r_item.opcode;
    assign o_res.word_index             = r_item.index;
    assign o_res.packet_end             = r_item.last;
    assign o_res.forward_to_renderer    = r_item.fwd;
    assign o_res.error_code             = r_item.err;
    assign o_res.draw_mode_bits         = r_draw_mode;
    assign o_res.texture_window_bits    = r_tex_window;
    assign o_res.area_top_left_bits     = r_area_tl;
    assign o_res.area_bottom_right_bits = r_area_br;
    assign o_res.draw_offset_bits       = r_draw_offs;
    assign o_res.mask_setting_bits      = r_mask;

endmodule

@@ sv/gpu_command_word_framer.sv @@
// Path: an accepted word is registered in the queue, then in the output register on o_res.
// Throughput: one word per cycle unless o_res stalls; the framer and state stage each take
//   one word per cycle and the default two-entry queue absorbs a stall on either side.
// Reset (i_rst_n low, synchronous): framer goes idle, queue and output register empty,
//   all drawing-state registers cleared to zero.
//
// Structure:
//   gcwf_front - tracks packet framing (words left, opcode, position), looks up the packet
//                length, flags renderer packets, picks which state register an E1..E6
//                word loads and works out the error code.
//   gcwf_queue - short FIFO of classified items.
//   gcwf_back  - loads the drawing-state registers and holds the output register; the
//                result carries the state after its own word was applied.
`include "gpu_command_word_framer_macros.svh"

module gpu_command_word_framer import gcwf_pkg::*; #(
    parameter int MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF,  // 12..16
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF        // 2 or more
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcwf_cmd_if.sink   i_cmd,
    gcwf_res_if.source o_res
);

    logic    push_valid;
    logic    push_ready;
    t_q_item push_item;
    logic    pop_valid;
    logic    pop_ready;
    t_q_item pop_item;

    gcwf_front #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    gcwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    gcwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_item  (pop_item),
        .o_res       (o_res)
    );

    // errors only ever appear on the opcode word of a packet
    `GCWF_ASSERT_NOW(a_err_on_first_word, i_clk, i_rst_n,
        o_res.valid && o_res.word_index != '0, o_res.error_code == ERR_NONE,
        "error code on a parameter word")

    // an unknown opcode always closes a one-word packet that is not forwarded
    `GCWF_ASSERT_NOW(a_unknown_single, i_clk, i_rst_n,
        o_res.valid && o_res.error_code == ERR_UNKNOWN_OP,
        o_res.packet_end && !o_res.forward_to_renderer,
        "unknown opcode not framed as a single dropped word")

    // reserved depth flag only from a draw mode word that carries it, and it was loaded
    `GCWF_ASSERT_NOW(a_tex_depth_src, i_clk, i_rst_n,
        o_res.valid && o_res.error_code == ERR_TEX_DEPTH,
        o_res.packet_opcode == OP_DRAW_MODE &&
            o_res.draw_mode_bits[8:7] == TEX_DEPTH_RSVD,
        "texture depth error without a reserved draw mode load")

endmodule

@@ dv/gpu_command_word_framer_tb.sv @@
// Self-checking testbench for gpu_command_word_framer: feeds command word packets with
// random bursts and output stalls, predicts every framed result and checks it field by field.
// Depends on gcwf_pkg, gcwf_if and the framer RTL.
module gpu_command_word_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcwf_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int MAX_WORDS      = MAX_PACKET_WORDS_DEF;  // packet length cap of the dut
    localparam int RANDOM_WORDS   = 2000;                  // random words after the directed part
    localparam int CYCLE_LIMIT    = 400000;                // well above the slowest clean run
    localparam int DRAIN_CYCLES   = 20;                    // quiet cycles after the last result
    localparam int MAX_ERR_LINES  = 50;                    // keeps the log short on a bad build
    localparam int N_OPS          = 33;

    // 12-word shaded textured quad, one of the two longest packets in the table
    localparam logic [OPCODE_W-1:0] OP_SHADED_TEX_QUAD = 8'h3C;

    // Opcode table and the packet length of each entry, in matching order.
    localparam logic [N_OPS-1:0][OPCODE_W-1:0] KNOWN_OPS = {
        OP_NOP, 8'h01, 8'h02, 8'h20,
        8'h28, 8'h29, 8'h2A, 8'h2B,
        8'h2C, 8'h2D, 8'h2F, 8'h30, 8'h38,
        OP_SHADED_TEX_QUAD, 8'h3E,
        8'h40, 8'h60,
        8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
        8'h75, OP_TEX_RECT16, OP_VRAM_COPY, 8'hA0, 8'hC0,
        OP_DRAW_MODE, OP_TEX_WINDOW, OP_AREA_TL, OP_AREA_BR, OP_DRAW_OFFS, OP_MASK_BIT
    };
    localparam logic [N_OPS-1:0][INDEX_W-1:0] KNOWN_LENS = {
        4'd1, 4'd1, 4'd3, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5,
        4'd9, 4'd9, 4'd9, 4'd6, 4'd8,
        4'd12, 4'd12,
        4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd2,
        4'd3, 4'd3, 4'd5, 4'd3, 4'd3,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    // One framed word as the result channel shows it.
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic                last;
        logic                fwd;
        logic [ERR_W-1:0]    err;
        logic [DMODE_W-1:0]  draw_mode;
        logic [TWIN_W-1:0]   tex_window;
        logic [AREA_W-1:0]   area_tl;
        logic [AREA_W-1:0]   area_br;
        logic [OFFS_W-1:0]   draw_offs;
        logic [MASK_W-1:0]   mask;
    } framed_word_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    gcwf_cmd_if cmd_ch ();
    gcwf_res_if res_ch ();

    gpu_command_word_framer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Framing and drawing-state shadow, advanced once per accepted word
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]  words_due     = '0;  // 0: next word opens a packet
    logic [OPCODE_W-1:0] pkt_op        = '0;
    logic [INDEX_W-1:0]  pkt_pos       = '0;
    logic [DMODE_W-1:0]  draw_mode_q   = '0;
    logic [TWIN_W-1:0]   tex_window_q  = '0;
    logic [AREA_W-1:0]   area_tl_q     = '0;
    logic [AREA_W-1:0]   area_br_q     = '0;
    logic [OFFS_W-1:0]   draw_offs_q   = '0;
    logic [MASK_W-1:0]   mask_q        = '0;

    logic [WORD_W-1:0] cmd_words[$];          // words still to be driven
    framed_word_t      expected_frames[$];    // predicted results, oldest first
    int unsigned       error_count  = 0;
    int unsigned       result_count = 0;
    int unsigned       cycle_count  = 0;

    // 0 for an opcode that is not in the table
    function automatic int unsigned table_length(input logic [OPCODE_W-1:0] op);
        for (int k = 0; k < N_OPS; k++) begin
            if (KNOWN_OPS[k] == op) begin
                return KNOWN_LENS[k];
            end
        end
        return 0;
    endfunction

    function automatic logic feeds_renderer(input logic [OPCODE_W-1:0] op);
        if (table_length(op) == 0) return 1'b0;
        if (op == OP_NOP || op == OP_TEX_RECT16 || op == OP_VRAM_COPY) return 1'b0;
        if (op >= OP_DRAW_MODE && op <= OP_MASK_BIT) return 1'b0;
        return 1'b1;
    endfunction

    // Frames one word and applies it to the shadow state; the result carries
    // the drawing state after this word.
    function automatic framed_word_t frame_next_word(input logic [WORD_W-1:0] w);
        framed_word_t     r;
        int unsigned      len;
        logic [ERR_W-1:0] err;
        logic             last;
        err = ERR_NONE;
        if (words_due == '0) begin
            // idle: top byte opens a packet
            pkt_op  = w[31:24];
            pkt_pos = '0;
            len     = table_length(pkt_op);
            if (len == 0) begin
                // unknown opcode frames as a one-word packet
                err = ERR_UNKNOWN_OP;
                len = 1;
            end
            if (len > MAX_WORDS) len = MAX_WORDS;
            words_due = len[INDEX_W-1:0];
            if (words_due == '0) words_due = 1;
        end
        r.index   = pkt_pos;
        words_due = words_due - 1'b1;
        last      = (words_due == '0);
        pkt_pos   = last ? '0 : pkt_pos + 1'b1;

        if (last && err == ERR_NONE) begin
            case (pkt_op)
                OP_DRAW_MODE: begin
                    // loaded even with the reserved depth code
                    draw_mode_q = w[DMODE_W-1:0];
                    if (w[8:7] == TEX_DEPTH_RSVD) err = ERR_TEX_DEPTH;
                end
                OP_TEX_WINDOW: tex_window_q = w[TWIN_W-1:0];
                OP_AREA_TL:    area_tl_q    = w[AREA_W-1:0];
                OP_AREA_BR:    area_br_q    = w[AREA_W-1:0];
                OP_DRAW_OFFS:  draw_offs_q  = w[OFFS_W-1:0];
                OP_MASK_BIT:   mask_q       = w[MASK_W-1:0];
                default: ;
            endcase
        end

        r.word       = w;
        r.opcode     = pkt_op;
        r.last       = last;
        r.fwd        = feeds_renderer(pkt_op);
        r.err        = err;
        r.draw_mode  = draw_mode_q;
        r.tex_window = tex_window_q;
        r.area_tl    = area_tl_q;
        r.area_br    = area_br_q;
        r.draw_offs  = draw_offs_q;
        r.mask       = mask_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_ERR_LINES) begin
            $display("gpu_command_word_framer_tb: result %0d: %s", result_count, msg);
        end
    endtask

    task automatic compare_field(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    // Queues one well-formed packet with random content. A quarter of the
    // parameter words carry a valid opcode in the top byte, which must be
    // passed through without being decoded.
    task automatic queue_packet(input logic [OPCODE_W-1:0] op);
        int unsigned len;
        len = table_length(op);
        if (len == 0) len = 1;
        cmd_words.push_back({op, 24'($urandom)});
        for (int k = 1; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                cmd_words.push_back({KNOWN_OPS[$urandom_range(0, N_OPS - 1)], 24'($urandom)});
            end else begin
                cmd_words.push_back($urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Command driver: bursts of random length with random gaps. Every
    // accepted item is framed by the shadow at the edge that takes it.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.cmd_word <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                expected_frames.push_back(frame_next_word(cmd_ch.cmd_word));
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end else if (cmd_words.size() > 0) begin
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.cmd_word <= cmd_words.pop_front();
                    if (burst_left <= 1) begin
                        // half the bursts run straight into the next one
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: ready steps through a 16-bit pattern, redrawn each
    // pass - always ready, random, mostly ready or mostly stalled.
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = '1;
    int unsigned pattern_pos   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            pattern_pos = 0;
        end else begin
            if (pattern_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom)
                                           | (16'd1 << $urandom_range(0, 15));
                endcase
            end
            res_ch.ready <= ready_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    framed_word_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_frames.size() == 0) begin
                report_error($sformatf("unexpected result, word 0x%0h", res_ch.word_out));
            end else begin
                want = expected_frames.pop_front();
                compare_field("word_out",               res_ch.word_out,               want.word);
                compare_field("packet_opcode",          res_ch.packet_opcode,          want.opcode);
                compare_field("word_index",             res_ch.word_index,             want.index);
                compare_field("packet_end",             res_ch.packet_end,             want.last);
                compare_field("forward_to_renderer",    res_ch.forward_to_renderer,    want.fwd);
                compare_field("error_code",             res_ch.error_code,             want.err);
                compare_field("draw_mode_bits",         res_ch.draw_mode_bits,         want.draw_mode);
                compare_field("texture_window_bits",    res_ch.texture_window_bits,    want.tex_window);
                compare_field("area_top_left_bits",     res_ch.area_top_left_bits,     want.area_tl);
                compare_field("area_bottom_right_bits", res_ch.area_bottom_right_bits, want.area_br);
                compare_field("draw_offset_bits",       res_ch.draw_offset_bits,       want.draw_offs);
                compare_field("mask_setting_bits",      res_ch.mask_setting_bits,      want.mask);
            end
            result_count++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gpu_command_word_framer_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned directed_words;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd_word = '0;
        res_ch.ready    = 1'b0;

        // Directed: word extremes, unknown opcodes, reserved texture depth, every state command,
        // draw mode and mask at both extremes, the most negative draw offsets.
        cmd_words.push_back(32'h0000_0000);                 // nop, all zeros
        cmd_words.push_back(32'hFFFF_FFFF);                 // unknown opcode, all ones
        cmd_words.push_back({OP_DRAW_MODE, 24'hFF_FFFF});   // reserved depth, still loaded
        cmd_words.push_back({OP_DRAW_MODE, 24'h00_0080});   // depth code 1
        cmd_words.push_back({OP_DRAW_MODE, 24'h00_0000});
        cmd_words.push_back({OP_TEX_WINDOW, 24'hFF_FFFF});
        cmd_words.push_back({OP_AREA_TL, 24'h0F_FFFF});
        cmd_words.push_back({OP_AREA_BR, 24'hF0_0000});     // only bits above the field set
        cmd_words.push_back({OP_DRAW_OFFS, 24'h20_0400});   // x and y at -1024
        cmd_words.push_back({OP_MASK_BIT, 24'hFF_FFFF});
        cmd_words.push_back({OP_MASK_BIT, 24'h00_0000});
        cmd_words.push_back(32'h0300_0000);                 // unknown opcode, zero params
        // longest packet; its parameters look like opcodes and must not be decoded
        cmd_words.push_back({OP_SHADED_TEX_QUAD, 24'h00_0000});
        for (int k = 1; k < 12; k++) begin
            case (k % 3)
                0:       cmd_words.push_back({OP_DRAW_MODE, 24'hFF_FFFF});
                1:       cmd_words.push_back(32'hFFFF_FFFF);
                default: cmd_words.push_back(32'h0000_0000);
            endcase
        end
        // a known packet that stays away from the renderer
        queue_packet(OP_TEX_RECT16);
        directed_words = cmd_words.size();

        // Random: mostly well-formed packets; the rest raw words that open
        // unknown or arbitrary packets and so break up the framing.
        while (cmd_words.size() < directed_words + RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_packet(KNOWN_OPS[$urandom_range(0, N_OPS - 1)]);
            end else begin
                cmd_words.push_back($urandom);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until everything is driven and every prediction has been checked
        do begin
            @(posedge i_clk);
        end while (cmd_words.size() != 0 || cmd_ch.valid || expected_frames.size() != 0);
        // a late or extra result would show up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("gpu_command_word_framer_tb: done, clean");
        end else begin
            $display("gpu_command_word_framer_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/gcwf_pkg.sv
sv/gcwf_if.sv
sv/gcwf_front.sv
sv/gcwf_queue.sv
sv/gcwf_back.sv
sv/gpu_command_word_framer.sv
dv/gpu_command_word_framer_tb.sv
